FILE: sv/olis_pkg.sv
// Shared types, constants and helpers for the offered-load injector.
`default_nettype none

package olis_pkg;

  localparam int unsigned NOW_W  = 64;
  localparam int unsigned CRED_W = 5;
  localparam int unsigned SPAN_W = 40;
  localparam int unsigned IVL_W  = 32;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned ROUNDS = 4;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [2:0]        MAX_LOADS    = 3'd4;
  localparam logic [IVL_W-1:0]  INTERVAL_RST = 32'd1000;
  localparam logic [2:0]        LOADS_RST    = 3'd1;
  localparam logic [SPAN_W-1:0] WARMUP_RST   = 40'd5000000;
  localparam logic [SPAN_W-1:0] COLLECT_RST  = 40'd20000000;
  localparam logic [SPAN_W-1:0] DRAIN_RST    = 40'd50000000;

  localparam logic KIND_SEND    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;
  localparam logic REQ_TICK     = 1'b0;
  localparam logic REQ_RECV     = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERVAL_0 = 4'd0,
    REG_INTERVAL_1 = 4'd1,
    REG_INTERVAL_2 = 4'd2,
    REG_INTERVAL_3 = 4'd3,
    REG_LOAD_COUNT = 4'd4,
    REG_WARMUP     = 4'd5,
    REG_COLLECT    = 4'd6,
    REG_DRAIN      = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [ROUNDS-1:0][IVL_W-1:0] interval;
    logic [2:0]                   load_count;
    logic [SPAN_W-1:0]            warmup;
    logic [SPAN_W-1:0]            collect;
    logic [SPAN_W-1:0]            drain;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    interval:   {ROUNDS{INTERVAL_RST}},
    load_count: LOADS_RST,
    warmup:     WARMUP_RST,
    collect:    COLLECT_RST,
    drain:      DRAIN_RST
  };

  // new span values, flagged when warmup or collect is written
  typedef struct packed {
    logic              upd;
    logic [SPAN_W-1:0] warmup;
    logic [SPAN_W-1:0] collect;
  } span_upd_t;

  // classified input item as it sits in the queue
  typedef struct packed {
    logic              is_rx;
    logic [NOW_W-1:0]  now;
    logic [CRED_W-1:0] credits;
    logic [NOW_W-1:0]  lat;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [NOW_W-1:0] send_stamp;
    logic [1:0]       round_index;
    logic [NOW_W-1:0] lat_sum;
    logic [NOW_W-1:0] lat_sum_sq;
    logic [NOW_W-1:0] lat_min;
    logic [NOW_W-1:0] lat_max;
    logic [CNT_W-1:0] lat_count;
    logic [NOW_W-1:0] backlog;
    logic             all_done;
    logic             last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RX_CHK,
    ST_RX_MUL0,
    ST_RX_MUL1,
    ST_RX_SQ,
    ST_TK_CHK,
    ST_TK_CLOSE,
    ST_TK_ARM0,
    ST_TK_ARM1,
    ST_TK_SEND
  } back_state_t;

  // zero counts as one round, anything above the maximum as the maximum
  function automatic logic [2:0] rounds_to_run(input logic [2:0] lc);
    logic [2:0] n;
    n = lc;
    if (n == 3'd0) n = 3'd1;
    if (n > MAX_LOADS) n = MAX_LOADS;
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: sv/olis_queue.sv
// Two-entry FIFO of classified items between front and back.
`default_nettype none

module olis_queue
  import olis_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  item_t      push_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      head,
  output logic       not_empty
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  item_t           mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   fill;

  assign full      = (fill == (PtrW+1)'(Depth));
  assign not_empty = (fill != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

FILE: sv/olis_front.sv
// Input side: takes items off the stream, classifies them, works out latency.
`default_nettype none

module olis_front
  import olis_pkg::*;
(
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,
  input  wire logic         s_axis_tuser,
  input  wire logic         q_full,
  output logic              q_push,
  output item_t             q_item
);

  logic [NOW_W-1:0] stamp;

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;
  assign stamp         = s_axis_tdata[132:69];

  always_comb begin
    q_item.is_rx   = (s_axis_tuser == REQ_RECV);
    q_item.now     = s_axis_tdata[63:0];
    q_item.credits = s_axis_tdata[68:64];
    // latency is a wrapping 64-bit difference; only used for receives
    q_item.lat     = s_axis_tdata[63:0] - stamp;
  end

endmodule

`default_nettype wire

FILE: sv/olis_back.sv
// Back end: round scheduler, send pacing, latency statistics and output register.
`default_nettype none

module olis_back
  import olis_pkg::*;
#(
  parameter int unsigned MAX_BURST = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  cfg_t       cfg,
  input  span_upd_t  span,
  input  wire logic  q_vld,
  input  item_t      q_item,
  output logic       q_pop,
  output res_t       out,
  output logic       out_valid,
  input  wire logic  out_ready
);

  localparam int unsigned BurstW = $clog2(MAX_BURST + 1);

  back_state_t       state;
  back_state_t       state_next;

  item_t             cur;
  logic [BurstW-1:0] cnt;

  logic [NOW_W-1:0]  next_send;
  logic [NOW_W-1:0]  record_from;
  logic [NOW_W-1:0]  round_end_at;
  logic [1:0]        round_no;
  logic [NOW_W-1:0]  acc_sum;
  logic [NOW_W-1:0]  acc_sum_sq;
  logic [NOW_W-1:0]  acc_min;
  logic [NOW_W-1:0]  acc_max;
  logic [CNT_W-1:0]  acc_count;
  logic              finished;

  logic [NOW_W-1:0]  p0;
  logic [31:0]       p1;
  logic [NOW_W-1:0]  sq_lo;
  logic [31:0]       sq_cross;

  res_t              pend;
  logic              pend_vld;
  res_t              sum_res;
  res_t              send_res;
  res_t              out_res;

  logic              out_free;
  logic              out_load;
  logic              send_due;
  logic              take;
  logic              send_fire;
  logic              flush;
  logic              fin_new;
  logic [BurstW-1:0] credits_cl;

  assign out_free   = !out_valid || out_ready;
  assign out_load   = (send_fire && pend_vld) || flush;
  assign send_due   = (cnt != '0) && (next_send <= cur.now);
  assign fin_new    = ({1'b0, round_no} + 3'd1) >= rounds_to_run(cfg.load_count);
  assign credits_cl = (int'(q_item.credits) > MAX_BURST) ? BurstW'(MAX_BURST)
                                                         : BurstW'(q_item.credits);
  assign sq_lo      = cur.lat[31:0] * cur.lat[31:0];
  assign sq_cross   = cur.lat[31:0] * cur.lat[63:32];
  assign q_pop      = take;

  always_comb begin
    state_next = state;
    take       = 1'b0;
    send_fire  = 1'b0;
    flush      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_vld) begin
          take       = 1'b1;
          state_next = q_item.is_rx ? ST_RX_CHK : ST_TK_CHK;
        end
      end
      ST_RX_CHK:  state_next = (record_from <= cur.now) ? ST_RX_MUL0 : ST_IDLE;
      ST_RX_MUL0: state_next = ST_RX_MUL1;
      ST_RX_MUL1: state_next = ST_RX_SQ;
      ST_RX_SQ:   state_next = ST_IDLE;
      ST_TK_CHK: begin
        state_next = (!finished && cur.now >= round_end_at) ? ST_TK_CLOSE : ST_TK_SEND;
      end
      ST_TK_CLOSE: state_next = fin_new ? ST_TK_SEND : ST_TK_ARM0;
      ST_TK_ARM0:  state_next = ST_TK_ARM1;
      ST_TK_ARM1:  state_next = ST_TK_SEND;
      ST_TK_SEND: begin
        // hold one result back so the last one of a tick can be flagged
        if (send_due) begin
          if (!pend_vld || out_free) send_fire = 1'b1;
        end else if (pend_vld) begin
          if (out_free) begin
            flush      = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result words built from the current round state
  always_comb begin
    sum_res             = '0;
    sum_res.kind        = KIND_SUMMARY;
    sum_res.round_index = round_no;
    sum_res.lat_sum     = acc_sum;
    sum_res.lat_sum_sq  = acc_sum_sq;
    sum_res.lat_min     = acc_min;
    sum_res.lat_max     = acc_max;
    sum_res.lat_count   = acc_count;
    sum_res.backlog     = (round_end_at <= next_send) ? '0 : round_end_at - next_send;
    sum_res.all_done    = fin_new;

    send_res             = '0;
    send_res.kind        = KIND_SEND;
    send_res.send_stamp  = next_send;
    send_res.round_index = round_no;
    send_res.all_done    = finished;

    out_res      = pend;
    out_res.last = flush;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      next_send    <= '0;
      record_from  <= NOW_W'(WARMUP_RST);
      round_end_at <= NOW_W'(WARMUP_RST) + NOW_W'(COLLECT_RST);
      round_no     <= '0;
      acc_sum      <= '0;
      acc_sum_sq   <= '0;
      acc_min      <= '1;
      acc_max      <= '0;
      acc_count    <= '0;
      finished     <= 1'b0;
      pend_vld     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;

      out_valid <= out_load || (out_valid && !out_ready);
      if (flush) pend_vld <= 1'b0;

      if (take) cnt <= credits_cl;

      if (span.upd && round_no == 2'd0 && !finished) begin
        record_from  <= NOW_W'(span.warmup);
        round_end_at <= NOW_W'(span.warmup) + NOW_W'(span.collect);
      end

      unique case (state)
        ST_RX_MUL0: begin
          acc_sum <= acc_sum + cur.lat;
          if (cur.lat < acc_min) acc_min <= cur.lat;
          if (cur.lat > acc_max) acc_max <= cur.lat;
          if (acc_count != '1) acc_count <= acc_count + 1'b1;
        end
        ST_RX_MUL1: acc_sum_sq <= acc_sum_sq + p0;
        ST_RX_SQ:   acc_sum_sq <= acc_sum_sq + {p1[30:0], 1'b0, 32'b0};
        ST_TK_CLOSE: begin
          pend_vld <= 1'b1;
          finished <= fin_new;
          if (!fin_new) begin
            round_no   <= round_no + 1'b1;
            acc_sum    <= '0;
            acc_sum_sq <= '0;
            acc_min    <= '1;
            acc_max    <= '0;
            acc_count  <= '0;
            next_send  <= round_end_at + NOW_W'(cfg.drain);
          end
        end
        ST_TK_ARM0: record_from  <= next_send + NOW_W'(cfg.warmup);
        ST_TK_ARM1: round_end_at <= record_from + NOW_W'(cfg.collect);
        ST_TK_SEND: begin
          if (send_fire) begin
            pend_vld  <= 1'b1;
            cnt       <= cnt - 1'b1;
            next_send <= next_send + NOW_W'(cfg.interval[round_no]);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) cur <= q_item;
    if (state == ST_RX_MUL0) p0 <= sq_lo;
    if (state == ST_RX_MUL1) p1 <= sq_cross;

    if (out_load) out <= out_res;

    if (state == ST_TK_CLOSE) begin
      pend <= sum_res;
    end else if (send_fire) begin
      pend <= send_res;
    end
  end

endmodule

`default_nettype wire

FILE: sv/offered_load_injector_with_latency_stats.sv
// Top level of the paced packet injector with latency statistics.
//
// Input stream (s_axis): tuser = req_type (tick or receive). A tick carries the
// time and send credits; a receive carries the time and the packet's send stamp.
// Output stream (m_axis): tuser = kind (send or round summary), tlast marks the
// last result caused by one input item.
// Config channel: cfg_index picks the register, cfg_data the value; always ready.
// Sequencing, set by the back-end sequencer: a receive passes a check state and,
// after warmup ends, the multiply and square states. A tick passes a check state,
// a close state when a round closes, arm states when a next round is armed, and
// the send state for its send stamps. Results leave through one output register.
// The two-entry input queue keeps accepting while the back end works on an item.
// If the receiver stalls, the back end holds one result in reserve and waits;
// the queue then fills and s_axis_tready falls.
// Reset (rst, synchronous) restores default registers, round 0, empty statistics,
// and drops any queued items and pending results.
`default_nettype none

module offered_load_injector_with_latency_stats
  import olis_pkg::*;
#(
  parameter int unsigned MAX_BURST = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // input transfers
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,  // now[63:0], send_credits[68:64],
                                           // sent_stamp[132:69], zero pad
  input  wire logic         s_axis_tuser,  // req_type
  // result transfers
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [423:0]      m_axis_tdata,  // send_stamp[63:0], round_index[65:64],
                                           // lat_sum[129:66], lat_sum_sq[193:130],
                                           // lat_min[257:194], lat_max[321:258],
                                           // lat_count[353:322], backlog[417:354],
                                           // all_done[418], zero pad
  output logic              m_axis_tuser,  // kind
  output logic              m_axis_tlast,  // last
  // configuration writes
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [3:0]   cfg_index,
  input  wire logic [39:0]  cfg_data
);

  cfg_t      cfg;
  cfg_t      cfg_next;
  span_upd_t span;

  logic      q_push;
  logic      q_full;
  item_t     q_in;
  logic      q_pop;
  item_t     q_head;
  logic      q_vld;

  res_t      out;
  logic      out_valid;

  assign cfg_ready = 1'b1;

  // register file decode; unknown indexes are dropped
  always_comb begin
    cfg_next = cfg;
    span.upd = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index) inside
        REG_INTERVAL_0, REG_INTERVAL_1, REG_INTERVAL_2, REG_INTERVAL_3:
          cfg_next.interval[cfg_index[1:0]] = cfg_data[IVL_W-1:0];
        REG_LOAD_COUNT: cfg_next.load_count = cfg_data[2:0];
        REG_WARMUP: begin
          cfg_next.warmup = cfg_data;
          span.upd        = 1'b1;
        end
        REG_COLLECT: begin
          cfg_next.collect = cfg_data;
          span.upd         = 1'b1;
        end
        REG_DRAIN: cfg_next.drain = cfg_data;
        default: ;
      endcase
    end
    span.warmup  = cfg_next.warmup;
    span.collect = cfg_next.collect;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RST;
    end else begin
      cfg <= cfg_next;
    end
  end

  olis_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  olis_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_vld)
  );

  olis_back #(
    .MAX_BURST (MAX_BURST)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .span      (span),
    .q_vld     (q_vld),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out       (out),
    .out_valid (out_valid),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out.kind;
  assign m_axis_tlast  = out.last;
  assign m_axis_tdata  = {5'b0, out.all_done, out.backlog, out.lat_count, out.lat_max,
                          out.lat_min, out.lat_sum_sq, out.lat_sum, out.round_index,
                          out.send_stamp};

`ifndef NO_ASSERTIONS
  // the queue is never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("input queue overflow");

  // a send result carries no statistics
  a_send_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.kind == KIND_SEND |-> out.backlog == '0 && out.lat_count == '0)
    else $error("send result carries statistics");

  // a summary with recorded latencies has min not above max
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.kind == KIND_SUMMARY && out.lat_count != '0 |->
      out.lat_min <= out.lat_max)
    else $error("summary minimum above maximum");
`endif

endmodule

`default_nettype wire

FILE: test/tb_olis_pkg.sv
// Scoreboard for the offered-load injector: predicts results of accepted items and checks them.
`timescale 1ns / 1ps

package tb_olis_pkg;
  import olis_pkg::*;

  localparam int unsigned BURST_CAP = 16;

  class injector_scoreboard;
    // copy of the register file
    logic [IVL_W-1:0]  interval [ROUNDS];
    logic [2:0]        load_count;
    logic [SPAN_W-1:0] warmup;
    logic [SPAN_W-1:0] collect;
    logic [SPAN_W-1:0] drain;
    // pacing and round state
    logic [NOW_W-1:0]  next_send;
    logic [NOW_W-1:0]  record_from;
    logic [NOW_W-1:0]  round_end_at;
    logic [1:0]        round_no;
    bit                finished;
    // latency statistics of the running round
    logic [NOW_W-1:0]  acc_sum;
    logic [NOW_W-1:0]  acc_sum_sq;
    logic [NOW_W-1:0]  acc_min;
    logic [NOW_W-1:0]  acc_max;
    logic [CNT_W-1:0]  acc_count;

    res_t              due_results[$];
    int                mismatches;

    function new();
      for (int i = 0; i < ROUNDS; i++) interval[i] = INTERVAL_RST;
      load_count   = LOADS_RST;
      warmup       = WARMUP_RST;
      collect      = COLLECT_RST;
      drain        = DRAIN_RST;
      next_send    = '0;
      record_from  = 64'(warmup);
      round_end_at = 64'(warmup) + 64'(collect);
      round_no     = '0;
      finished     = 1'b0;
      mismatches   = 0;
      clear_stats();
    endfunction

    function void clear_stats();
      acc_sum    = '0;
      acc_sum_sq = '0;
      acc_min    = '1;
      acc_max    = '0;
      acc_count  = '0;
    endfunction

    function int planned_rounds();
      int n;
      n = load_count;
      if (n == 0) n = 1;
      if (n > MAX_LOADS) n = MAX_LOADS;
      return n;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void append_result(res_t r);
      due_results.insert(due_results.size(), r);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SPAN_W-1:0] val);
      case (idx)
        REG_INTERVAL_0, REG_INTERVAL_1, REG_INTERVAL_2, REG_INTERVAL_3:
          interval[idx[1:0]] = val[IVL_W-1:0];
        REG_LOAD_COUNT: load_count = val[2:0];
        REG_WARMUP:     warmup = val;
        REG_COLLECT:    collect = val;
        REG_DRAIN:      drain = val;
        default:        return;
      endcase
      // round 0 times are measured from zero, so a span change moves them
      if ((idx == REG_WARMUP || idx == REG_COLLECT) && round_no == 0 && !finished) begin
        record_from  = 64'(warmup);
        round_end_at = 64'(warmup) + 64'(collect);
      end
    endfunction

    function void note_accepted_item(logic req, logic [NOW_W-1:0] now,
                                     logic [CRED_W-1:0] credits, logic [NOW_W-1:0] stamp);
      res_t            r;
      logic [NOW_W-1:0] lat;
      logic [NOW_W-1:0] end_t;
      int              cap;
      int              first;

      if (req == REQ_RECV) begin
        if (record_from <= now) begin
          lat        = now - stamp;
          acc_sum    = acc_sum + lat;
          acc_sum_sq = acc_sum_sq + lat * lat;
          if (lat < acc_min) acc_min = lat;
          if (lat > acc_max) acc_max = lat;
          if (acc_count != '1) acc_count = acc_count + 1'b1;
        end
        return;
      end

      first = due_results.size();
      if (!finished && now >= round_end_at) begin
        end_t = round_end_at;
        if (int'(round_no) + 1 >= planned_rounds()) finished = 1'b1;
        r             = '0;
        r.kind        = KIND_SUMMARY;
        r.round_index = round_no;
        r.lat_sum     = acc_sum;
        r.lat_sum_sq  = acc_sum_sq;
        r.lat_min     = acc_min;
        r.lat_max     = acc_max;
        r.lat_count   = acc_count;
        r.backlog     = (end_t <= next_send) ? '0 : end_t - next_send;
        r.all_done    = finished;
        append_result(r);
        if (!finished) begin
          round_no     = round_no + 2'd1;
          clear_stats();
          next_send    = end_t + 64'(drain);
          record_from  = next_send + 64'(warmup);
          round_end_at = end_t + 64'(drain) + 64'(warmup) + 64'(collect);
        end
      end

      cap = credits;
      if (cap > BURST_CAP) cap = BURST_CAP;
      for (int k = 0; k < cap && next_send <= now; k++) begin
        r             = '0;
        r.kind        = KIND_SEND;
        r.send_stamp  = next_send;
        r.round_index = round_no;
        r.all_done    = finished;
        append_result(r);
        next_send = next_send + 64'(interval[round_no]);
      end
      if (due_results.size() > first) due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    function void compare(string name, logic [NOW_W-1:0] want, logic [NOW_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing expected: kind %0d stamp %0h", got.kind, got.send_stamp);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare("kind", 64'(want.kind), 64'(got.kind));
      compare("send_stamp", want.send_stamp, got.send_stamp);
      compare("round_index", 64'(want.round_index), 64'(got.round_index));
      compare("lat_sum", want.lat_sum, got.lat_sum);
      compare("lat_sum_sq", want.lat_sum_sq, got.lat_sum_sq);
      compare("lat_min", want.lat_min, got.lat_min);
      compare("lat_max", want.lat_max, got.lat_max);
      compare("lat_count", 64'(want.lat_count), 64'(got.lat_count));
      compare("backlog", want.backlog, got.backlog);
      compare("all_done", 64'(want.all_done), 64'(got.all_done));
      compare("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

endpackage

FILE: test/tb_top.sv
// Testbench top: drives ticks, receives and register writes into the injector and checks results.
`timescale 1ns / 1ps

module tb_top;
  import olis_pkg::*;
  import tb_olis_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;   // a few queued receives emit nothing
  localparam int unsigned HOLD_LEN      = 300;
  localparam int unsigned HOLD_AT_ITEM  = 70;
  localparam int unsigned CHUNK_ITEMS   = 50;
  // indexes outside the register list, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [423:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [3:0]   cfg_index = '0;
  logic [39:0]  cfg_data = '0;

  injector_scoreboard sb = new();

  int unsigned      accepted_inputs = 0;
  int unsigned      hold_cycles = 0;
  bit               hold_used = 1'b0;
  logic [NOW_W-1:0] time_cursor = '0;

  always #2 clk = ~clk;

  offered_load_injector_with_latency_stats #(.MAX_BURST(BURST_CAP)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // a stretch of the run where neither side idles
  function automatic bit steady_window();
    return accepted_inputs >= 140 && accepted_inputs < 180;
  endfunction

  // one long receiver hold-off part way through; input keeps coming so the
  // result path backs up into the input queue
  always @(posedge clk) begin
    if (!rst && !hold_used && accepted_inputs >= HOLD_AT_ITEM) begin
      hold_used   <= 1'b1;
      hold_cycles <= HOLD_LEN;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // result side ready: random stalls, none in the steady window, held low during reset and the hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_cycles == 0) && (steady_window() || $urandom_range(99) >= 31);
    end
  end

  // result monitor: every transfer is checked against the oldest prediction
  always @(posedge clk) begin
    res_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind        = m_axis_tuser;
      got.send_stamp  = m_axis_tdata[63:0];
      got.round_index = m_axis_tdata[65:64];
      got.lat_sum     = m_axis_tdata[129:66];
      got.lat_sum_sq  = m_axis_tdata[193:130];
      got.lat_min     = m_axis_tdata[257:194];
      got.lat_max     = m_axis_tdata[321:258];
      got.lat_count   = m_axis_tdata[353:322];
      got.backlog     = m_axis_tdata[417:354];
      got.all_done    = m_axis_tdata[418];
      got.last        = m_axis_tlast;
      sb.check_result(got);
    end
  end

  // hard stop if the run hangs or predictions never drain
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // one input transfer; valid stays high across back-to-back items
  task automatic offer_item(input logic req, input logic [NOW_W-1:0] now,
                            input logic [CRED_W-1:0] credits, input logic [NOW_W-1:0] stamp);
    if (!steady_window() && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while (!steady_window() && $urandom_range(99) < 31);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {3'b000, stamp, credits, now};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_accepted_item(req, now, credits, stamp);
    accepted_inputs++;
  endtask

  // register write; caller lowers cfg_valid after the last one
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SPAN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // block idle: all predicted results out, then time for trailing receives
  task automatic wait_block_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SPAN_W-1:0] pick_interval();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return 40'(32'hFFFF_FFFF);
    if (r < 20) return 40'd1;
    return 40'($urandom_range(1, 5000));
  endfunction

  function automatic logic [SPAN_W-1:0] pick_span();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 12) return '1;
    return 40'($urandom_range(0, 300000));
  endfunction

  // new pacing for a random chunk; the round count of the last chunk is zero (one round) to force the finish
  task automatic configure_chunk(input int chunk);
    logic [2:0] plan [4];
    plan = '{3'd4, 3'd2, 3'd5, 3'd0};
    cfg_write(REG_INTERVAL_0, pick_interval());
    cfg_write(REG_INTERVAL_1, pick_interval());
    cfg_write(REG_INTERVAL_2, pick_interval());
    cfg_write(REG_INTERVAL_3, pick_interval());
    cfg_write(REG_LOAD_COUNT, 40'(plan[chunk]));
    cfg_write(REG_WARMUP, pick_span());
    cfg_write(REG_COLLECT, pick_span());
    cfg_write(REG_DRAIN, (chunk == 1) ? '1 : pick_span());
    cfg_write(REG_SPARE_HI, 40'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  // tick: mostly time moving forward, sometimes straight to a round end or a send slot
  task automatic random_tick();
    logic [NOW_W-1:0]  t;
    logic [CRED_W-1:0] cr;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      t = {$urandom, $urandom};
    end else begin
      if (pick < 14 && !sb.finished) t = sb.round_end_at + $urandom_range(0, 2000);
      else if (pick < 20) t = sb.next_send - $urandom_range(0, 1);
      else t = time_cursor + $urandom_range(0, 20000);
      if (t > time_cursor) time_cursor = t;
    end
    cr = ($urandom_range(99) < 15) ? CRED_W'($urandom_range(0, 31))
                                   : CRED_W'($urandom_range(1, BURST_CAP));
    offer_item(REQ_TICK, t, cr, {$urandom, $urandom});
  endtask

  // receive: plausible latency near the cursor, with warmup edges and noise
  task automatic random_recv();
    logic [NOW_W-1:0] t;
    logic [NOW_W-1:0] stamp;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (pick < 8) t = {$urandom, $urandom};
    else if (pick < 16) t = sb.record_from - $urandom_range(0, 1);
    else t = time_cursor + $urandom_range(0, 5000);
    if ($urandom_range(99) < 10) stamp = {$urandom, $urandom};
    else stamp = t - $urandom_range(0, 60000);
    offer_item(REQ_RECV, t, CRED_W'($urandom_range(0, 31)), stamp);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default pacing: 1000 ps interval, warmup 5 us, round end at 25 us
    offer_item(REQ_TICK, 64'd0, 5'd0, '0);              // slot due, no credits
    offer_item(REQ_TICK, 64'd0, 5'd1, '1);              // first send at time zero
    offer_item(REQ_TICK, 64'd5000, 5'd17, '0);          // fewer due slots than credits
    offer_item(REQ_TICK, 64'd3000, 5'd16, '0);          // nothing due yet
    offer_item(REQ_RECV, 64'd100, 5'd31, 64'd0);        // before warmup: dropped
    offer_item(REQ_RECV, 64'd4999999, 5'd0, 64'd0);     // one ps short of recording
    offer_item(REQ_RECV, 64'd5000000, 5'd0, 64'd4000000);
    offer_item(REQ_RECV, '1, 5'd0, 64'd0);              // largest latency, square wraps
    offer_item(REQ_RECV, 64'd6000000, 5'd0, 64'd7000000); // stamp after now: wraps
    offer_item(REQ_RECV, 64'd5000001, 5'd0, 64'd5000001); // zero latency
    offer_item(REQ_TICK, 64'd200000, 5'd31, '1);        // credits beyond the burst cap
    offer_item(REQ_TICK, 64'd24999999, 5'd0, '0);       // just short of the round end
    s_axis_tvalid <= 1'b0;
    wait_block_idle();

    // extremes, with spans rewritten while round 0 is still running
    cfg_write(REG_INTERVAL_0, '0);
    cfg_write(REG_INTERVAL_1, 40'(32'hFFFF_FFFF));
    cfg_write(REG_INTERVAL_2, 40'd1);
    cfg_write(REG_INTERVAL_3, 40'($urandom_range(1, 5000)));
    cfg_write(REG_LOAD_COUNT, 40'd7);
    cfg_write(REG_WARMUP, '0);
    cfg_write(REG_COLLECT, '1);
    cfg_write(REG_DRAIN, '0);
    cfg_write(REG_SPARE_LO, '1);
    cfg_valid <= 1'b0;
    offer_item(REQ_TICK, 64'hFF_FFFF_FFFE, 5'd3, '0);   // zero interval: same stamp thrice
    offer_item(REQ_RECV, 64'hFF_FFFF_FFF0, 5'd0, 64'd22000);
    offer_item(REQ_TICK, 64'hFF_FFFF_FFFF, 5'd16, '0);  // round 0 closes, round 1 armed
    s_axis_tvalid <= 1'b0;
    time_cursor = 64'hFF_FFFF_FFFF;

    for (int chunk = 0; chunk < 4; chunk++) begin
      wait_block_idle();
      configure_chunk(chunk);
      for (int k = 0; k < CHUNK_ITEMS; k++) begin
        if ($urandom_range(99) < 60) random_tick();
        else random_recv();
      end
      s_axis_tvalid <= 1'b0;
    end

    wait_block_idle();
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
